// File: rtl/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  localparam logic [7:0] SEP_BYTE = 8'h80;
  localparam int unsigned LEN_SLOT = 14;

  // initial hash value
  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    begin
      case (i)
        3'd0: r = 32'h6a09e667;
        3'd1: r = 32'hbb67ae85;
        3'd2: r = 32'h3c6ef372;
        3'd3: r = 32'ha54ff53a;
        3'd4: r = 32'h510e527f;
        3'd5: r = 32'h9b05688c;
        3'd6: r = 32'h1f83d9ab;
        default: r = 32'h5be0cd19;
      endcase
      return r;
    end
  endfunction

  // round constants
  function automatic logic [31:0] round_const(input logic [5:0] t);
    logic [31:0] k [64];
    begin
      k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/sha256_word_stream_hasher_unit.sv
`default_nettype none
// SHA-256 over a stream of 32-bit message words, first byte in bits 31..24.
// A request with end_of_message clear is written into the window; if it
// fills the 16-word block, the single round unit runs 64 rounds, one a
// cycle, then folds the working variables into the chain before it takes
// another request. A final request pads (separator, zero fill, 64-bit bit
// length), compresses one or two more blocks (one pad word a cycle while
// filling), then offers the eight digest words on the out channel, index 0
// first. in_ready is low while a block compresses, padding runs or the
// digest is being delivered.
module sha256_word_stream_hasher_unit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  sha256_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output sha256_pkg::out_item_t out_data
);
  import sha256_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_FOLD = 3'd2;
  localparam logic [2:0] ST_PAD = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] chain_r [8];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] win_r [16];
  logic [5:0]  round_r;
  logic [4:0]  fill_r;
  logic [63:0] len_r;
  logic        final_r;
  logic        sep_pend_r;
  logic        zero_blk_r;
  logic        last_block_r;
  logic [2:0]  idx_r;

  // push path
  logic        push;
  logic [31:0] push_word;
  logic [63:0] len_nxt;
  logic [4:0]  fill_after;

  // round datapath
  logic [3:0]  t_idx;
  logic [31:0] w2, w15, w7, w16, s0, s1, w_new, w_cur;
  logic [31:0] t1, t2, bs0, bs1, ch, mj;
  logic        accept;
  logic [2:0]  cnt;
  logic [31:0] keep, sep;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // message word with separator for a final request
  always_comb begin
    cnt = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
    keep = (cnt == 3'd0) ? 32'd0 : (32'hffffffff << (6'd32 - {cnt, 3'b000}));
    sep = {SEP_BYTE, 24'd0} >> {cnt, 3'b000};
  end

  always_comb begin
    push = 1'b0;
    push_word = in_data.message_word;
    len_nxt = len_r;
    if (state_r == ST_IDLE && accept) begin
      push = 1'b1;
      if (!in_data.end_of_message || cnt == 3'd4) begin
        len_nxt = len_r + 64'd32;
      end else begin
        len_nxt = len_r + {58'd0, cnt, 3'b000};
        push_word = (in_data.message_word & keep) | sep;
      end
    end else if (state_r == ST_PAD) begin
      push = 1'b1;
      if (sep_pend_r) push_word = {SEP_BYTE, 24'd0};
      else if (zero_blk_r) push_word = 32'd0;
      else if (fill_r == 5'(LEN_SLOT)) push_word = len_r[63:32];
      else if (fill_r == 5'(LEN_SLOT + 1)) push_word = len_r[31:0];
      else push_word = 32'd0;
    end else if (state_r == ST_OUT && out_ready && idx_r == 3'd7) begin
      len_nxt = 64'd0;
    end
    fill_after = fill_r + 5'd1;
  end

  // schedule and round
  always_comb begin
    t_idx = round_r[3:0];
    w2 = win_r[4'(t_idx - 4'd2)];
    w15 = win_r[4'(t_idx - 4'd15)];
    w7 = win_r[4'(t_idx - 4'd7)];
    w16 = win_r[t_idx];
    s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    w_new = s1 + w7 + s0 + w16;
    w_cur = (round_r < 6'd16) ? w16 : w_new;
    bs1 = {e_r[5:0], e_r[31:6]} ^ {e_r[10:0], e_r[31:11]} ^ {e_r[24:0], e_r[31:25]};
    ch = (e_r & f_r) ^ (~e_r & g_r);
    t1 = h_r + bs1 + ch + round_const(round_r) + w_cur;
    bs0 = {a_r[1:0], a_r[31:2]} ^ {a_r[12:0], a_r[31:13]} ^ {a_r[21:0], a_r[31:22]};
    mj = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
    t2 = bs0 + mj;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) begin
        if (fill_after == 5'd16) state_nxt = ST_ROUND;
        else if (in_data.end_of_message) state_nxt = ST_PAD;
      end
      ST_PAD: if (fill_after == 5'd16) state_nxt = ST_ROUND;
      ST_ROUND: if (round_r == 6'd63) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (last_block_r) state_nxt = ST_OUT;
        else if (final_r) state_nxt = ST_PAD;
        else state_nxt = ST_IDLE;
      end
      ST_OUT: if (out_ready && idx_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // window memory
  always_ff @(posedge clk) begin
    if (push) win_r[fill_r[3:0]] <= push_word;
    else if (state_r == ST_ROUND && round_r >= 6'd16) win_r[t_idx] <= w_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r <= 5'd0;
      len_r <= 64'd0;
      round_r <= 6'd0;
      final_r <= 1'b0;
      sep_pend_r <= 1'b0;
      zero_blk_r <= 1'b0;
      idx_r <= 3'd0;
      {a_r, b_r, c_r, d_r} <= '0;
      {e_r, f_r, g_r, h_r} <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= init_hash(3'(i));
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      if (push) fill_r <= (fill_after == 5'd16) ? 5'd0 : fill_after;
      // full final word: the separator goes in as its own word
      // separator in slot 14: that block ends in zeros, length goes in the next
      if (accept && in_data.end_of_message) begin
        final_r <= 1'b1;
        sep_pend_r <= (cnt == 3'd4);
        zero_blk_r <= (cnt != 3'd4) && (fill_r == 5'(LEN_SLOT));
      end else if (state_r == ST_PAD) begin
        sep_pend_r <= 1'b0;
        if (sep_pend_r) zero_blk_r <= (fill_r == 5'(LEN_SLOT));
        else if (fill_after == 5'd16) zero_blk_r <= 1'b0;
      end
      // load working variables when a block is full
      if (push && fill_after == 5'd16) begin
        round_r <= 6'd0;
        {a_r, b_r, c_r, d_r} <= {chain_r[0], chain_r[1], chain_r[2], chain_r[3]};
        {e_r, f_r, g_r, h_r} <= {chain_r[4], chain_r[5], chain_r[6], chain_r[7]};
      end else if (state_r == ST_ROUND) begin
        round_r <= round_r + 6'd1;
        h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
        d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
      end
      // fold into chain; the last block of a message goes to output
      if (state_r == ST_FOLD) begin
        chain_r[0] <= chain_r[0] + a_r; chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r; chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r; chain_r[5] <= chain_r[5] + f_r;
        chain_r[6] <= chain_r[6] + g_r; chain_r[7] <= chain_r[7] + h_r;
        if (last_block_r) idx_r <= 3'd0;
      end
      if (state_r == ST_OUT && out_ready) begin
        idx_r <= idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          final_r <= 1'b0;
          fill_r <= 5'd0;
          for (int i = 0; i < 8; i++) chain_r[i] <= init_hash(3'(i));
        end
      end
    end
  end

  // length words written: the block just compressed was the last one
  always_ff @(posedge clk) begin
    if (!rst_n) last_block_r <= 1'b0;
    else if (state_r == ST_PAD && fill_r == 5'(LEN_SLOT + 1) && !sep_pend_r && !zero_blk_r)
      last_block_r <= 1'b1;
    else if (state_r == ST_OUT) last_block_r <= 1'b0;
  end

  assign out_valid = (state_r == ST_OUT);
  always_comb begin
    out_data.digest_word = chain_r[idx_r];
    out_data.digest_index = idx_r;
    out_data.digest_last = (idx_r == 3'd7);
  end

endmodule
`default_nettype wire

// File: rtl/sha256_checker.sv
`default_nettype none
module sha256_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input sha256_pkg::out_item_t out_data
);
  import sha256_pkg::*;

  // no input taken while digest is offered
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("in_ready during digest");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("digest changed while stalled");

  // index steps by one after each taken word but the last
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.digest_last |=>
      out_valid && out_data.digest_index == 3'($past(out_data.digest_index) + 3'd1))
    else $error("digest index skipped");

  // last flag only on index seven
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.digest_last == (out_data.digest_index == 3'd7)))
    else $error("digest_last misplaced");
endmodule

bind sha256_word_stream_hasher_unit sha256_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
